/* src/assert_macros.svh */
// assertion macros for the checker file dtti_checker.sv
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define DTTI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// expression must never be true out of reset
`define DTTI_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

/* src/dtti_pkg.sv */
// types and constants for the decimal text to integer unit
// no dependencies
`default_nettype none

package dtti_pkg;

  typedef enum logic [3:0] {
    PH_START   = 4'b0001,
    PH_SIGN    = 4'b0010,
    PH_DIGITS  = 4'b0100,
    PH_STOPPED = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_EMPTY    = 3'd1,
    ERR_NODIGIT  = 3'd2,
    ERR_OVERFLOW = 3'd3,
    ERR_TRAILING = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    REG_SIGNED_MODE = 2'd0,
    REG_STRICT_MODE = 2'd1,
    REG_WIDE_MODE   = 2'd2
  } reg_idx_t;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;

  // type maximum divided by ten
  localparam logic [63:0] LIM_S32 = 64'd214748364;
  localparam logic [63:0] LIM_U32 = 64'd429496729;
  localparam logic [63:0] LIM_S64 = 64'd922337203685477580;
  localparam logic [63:0] LIM_U64 = 64'd1844674407370955161;

  // last digit of the type maximum (of the minimum's magnitude for TOP_SIGNED_NEG)
  localparam logic [3:0] TOP_SIGNED_POS = 4'd7;
  localparam logic [3:0] TOP_SIGNED_NEG = 4'd8;
  localparam logic [3:0] TOP_UNSIGNED   = 4'd5;

  localparam logic [63:0] MASK_32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] MASK_64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed_mode;
    logic strict_mode;
    logic wide_mode;
  } cfg_t;

  typedef struct packed {
    logic [63:0] acc;
    logic        neg;
    phase_t      phase;
    err_t        perr;
  } dtti_state_t;

  typedef struct packed {
    logic [63:0] number;
    logic        ok;
    err_t        err;
  } dtti_res_t;

  localparam dtti_state_t STATE_CLEAR = '{acc: 64'd0, neg: 1'b0, phase: PH_START,
                                         perr: ERR_NONE};

endpackage

`default_nettype wire

/* src/dtti_parse_step.sv */
// one character step of the parser and the end of string result
// depends on dtti_pkg
`default_nettype none

module dtti_parse_step (
  input  dtti_pkg::cfg_t        cfg_i,
  input  dtti_pkg::dtti_state_t cur_i,
  input  logic [7:0]            text_byte_i,
  input  logic                  has_byte_i,
  output dtti_pkg::dtti_state_t nxt_o,
  output dtti_pkg::dtti_res_t   res_o
);
  import dtti_pkg::*;

  logic        is_digit;
  logic [3:0]  digit;
  logic [3:0]  top;
  logic [63:0] lim;
  logic [63:0] mask;
  logic [63:0] acc_x10;
  logic        overflow;
  logic        do_digit;
  logic        do_fail;
  err_t        fail_code;
  logic        fail_any;
  err_t        fail_sel;
  dtti_state_t st;
  logic [63:0] v_masked;
  logic [63:0] v_final;
  err_t        end_err;

  assign is_digit = text_byte_i inside {[CHAR_ZERO:CHAR_NINE]};
  // ascii digits sit at 0x30..0x39
  assign digit    = text_byte_i[3:0];
  assign mask     = cfg_i.wide_mode ? MASK_64 : MASK_32;

  always_comb begin
    case ({cfg_i.signed_mode, cfg_i.wide_mode})
      2'b00:   lim = LIM_U32;
      2'b01:   lim = LIM_U64;
      2'b10:   lim = LIM_S32;
      default: lim = LIM_S64;
    endcase
    if (cfg_i.signed_mode) begin
      top = cur_i.neg ? TOP_SIGNED_NEG : TOP_SIGNED_POS;
    end else begin
      top = TOP_UNSIGNED;
    end
  end

  assign acc_x10  = {cur_i.acc[60:0], 3'b000} + {cur_i.acc[62:0], 1'b0} + {60'd0, digit};
  assign overflow = (cur_i.acc > lim) || ((cur_i.acc == lim) && (digit > top));

  always_comb begin
    st        = cur_i;
    do_digit  = 1'b0;
    do_fail   = 1'b0;
    fail_code = ERR_NODIGIT;
    fail_any  = 1'b0;
    fail_sel  = ERR_NODIGIT;
    if (has_byte_i) begin
      case (cur_i.phase)
        PH_START: begin
          if ((text_byte_i == CHAR_MINUS) && cfg_i.signed_mode) begin
            st.neg   = 1'b1;
            st.phase = PH_SIGN;
          end else if (text_byte_i == CHAR_PLUS) begin
            st.phase = PH_SIGN;
          end else if (is_digit) begin
            do_digit = 1'b1;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_NODIGIT;
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            do_digit = 1'b1;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_NODIGIT;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            do_digit = 1'b1;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_TRAILING;
          end
        end
        default: begin
        end
      endcase
    end

    if (do_digit && cfg_i.strict_mode && overflow) begin
      fail_any = 1'b1;
      fail_sel = ERR_OVERFLOW;
    end else if (do_digit) begin
      st.acc   = cfg_i.strict_mode ? acc_x10 : (acc_x10 & mask);
      st.phase = PH_DIGITS;
    end else if (do_fail) begin
      fail_any = 1'b1;
      fail_sel = fail_code;
    end

    if (fail_any) begin
      st.phase = PH_STOPPED;
      if (cfg_i.strict_mode && (cur_i.perr == ERR_NONE)) begin
        st.perr = fail_sel;
      end
    end
  end

  assign nxt_o = st;

  // end of string, taken on the state after this character
  always_comb begin
    end_err = ERR_NONE;
    if (cfg_i.strict_mode) begin
      if (st.perr != ERR_NONE) begin
        end_err = st.perr;
      end else if (st.phase == PH_START) begin
        end_err = ERR_EMPTY;
      end else if ((st.phase == PH_SIGN) || (st.phase == PH_STOPPED)) begin
        end_err = ERR_NODIGIT;
      end
    end

    v_masked = st.acc & mask;
    v_final  = st.neg ? ((~v_masked + 64'd1) & mask) : v_masked;
    if (!cfg_i.wide_mode && cfg_i.signed_mode && v_final[31]) begin
      v_final[63:32] = 32'hFFFF_FFFF;
    end
  end

  assign res_o.number = (end_err != ERR_NONE) ? 64'd0 : v_final;
  assign res_o.ok     = (end_err == ERR_NONE);
  assign res_o.err    = end_err;

endmodule

`default_nettype wire

/* src/decimal_text_to_integer_unit.sv */
// the last byte of a string passes through the input register and then the result register to result valid
// throughput: one byte per cycle unless a last byte waits on a full, stalled result register; the
// accumulator update (x10 plus digit, limit compare) is combinational, so bytes stream back to back
// a string yields one result on its last byte; a stalled result holds the pipe
// reset (rst_n low, synchronous): empty pipe, string state cleared,
// signed_mode=1 strict_mode=1 wide_mode=0
// depends on dtti_pkg and dtti_parse_step
`default_nettype none

module decimal_text_to_integer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_has_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_number,
  output logic        out_ok,
  output logic [2:0]  out_error_code
);
  import dtti_pkg::*;

  cfg_t        cfg_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_has_r;
  logic        s1_last_r;
  dtti_state_t state_r;
  dtti_state_t state_nxt;
  dtti_res_t   res_nxt;
  logic        out_valid_r;
  dtti_res_t   out_r;
  logic        s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.signed_mode <= 1'b1;
      cfg_r.strict_mode <= 1'b1;
      cfg_r.wide_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIGNED_MODE: cfg_r.signed_mode <= cfg_wdata;
        REG_STRICT_MODE: cfg_r.strict_mode <= cfg_wdata;
        REG_WIDE_MODE:   cfg_r.wide_mode   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // stage advances unless it must emit into a full, stalled result register
  assign s1_fire  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_text_byte;
      s1_has_r  <= in_has_byte;
      s1_last_r <= in_last_byte;
    end
  end

  dtti_parse_step u_step (
    .cfg_i       (cfg_r),
    .cur_i       (state_r),
    .text_byte_i (s1_byte_r),
    .has_byte_i  (s1_has_r),
    .nxt_o       (state_nxt),
    .res_o       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else if (s1_fire) begin
      state_r <= s1_last_r ? STATE_CLEAR : state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_number     = out_r.number;
  assign out_ok         = out_r.ok;
  assign out_error_code = out_r.err;

endmodule

`default_nettype wire

/* src/dtti_checker.sv */
// port level checks for decimal_text_to_integer_unit, bound to the top level
// depends on dtti_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module dtti_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_number,
  input wire logic        out_ok,
  input wire logic [2:0]  out_error_code
);
  import dtti_pkg::*;

  logic        out_stall;
  logic [67:0] out_payload;

  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {out_number, out_ok, out_error_code};

  // a stalled result transaction holds
  `DTTI_ASSERT(a_out_hold, clk, rst_n, out_stall |=> (out_valid && $stable(out_payload)))
  `DTTI_NEVER(a_ok_with_err, clk, rst_n, out_valid && out_ok && (out_error_code != ERR_NONE))
  `DTTI_NEVER(a_fail_zero, clk, rst_n, out_valid && !out_ok && (out_number != 64'd0))
  `DTTI_NEVER(a_fail_code, clk, rst_n, out_valid && !out_ok && (out_error_code == ERR_NONE))
  `DTTI_NEVER(a_code_range, clk, rst_n, out_valid && (out_error_code > ERR_TRAILING))

endmodule

bind decimal_text_to_integer_unit dtti_checker u_dtti_checker (.*);

`default_nettype wire
